// ----- rtl/ipsec_security_header_parser_top_assert.svh -----
// Assertion macros for the security header parser.
// Included by rtl modules that check their own logic; no other dependencies.
`ifndef IPSEC_SECURITY_HEADER_PARSER_TOP_ASSERT_SVH
`define IPSEC_SECURITY_HEADER_PARSER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define ISHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ishp assertion failed");
// next-cycle implication
`define ISHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ishp assertion failed");
`else
`define ISHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ISHP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/ishp_pkg.sv -----
// Shared types, character codes and name tables for the security header parser.
// No dependencies.
package ishp_pkg;

    localparam int KEY_COUNT = 4;
    localparam int VALUE_W   = 32;

    typedef logic [1:0]          t_status;
    typedef logic [VALUE_W-1:0]  t_value;

    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_NO_MECH    = 2'd1;
    localparam t_status ST_NO_KEY     = 2'd2;
    localparam t_status ST_ZERO_VALUE = 2'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    localparam logic [3:0] MECH_LEN = 4'd10;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_digit;

    typedef struct packed {
        t_status                        status;
        logic [KEY_COUNT-1:0][VALUE_W-1:0] value;
    } t_result;

    // "ipsec-3gpp"
    function automatic logic [7:0] mech_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h69;
            4'd1:    ch = 8'h70;
            4'd2:    ch = 8'h73;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h63;
            4'd5:    ch = 8'h2D;
            4'd6:    ch = 8'h33;
            4'd7:    ch = 8'h67;
            4'd8:    ch = 8'h70;
            4'd9:    ch = 8'h70;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // spi-c, spi-s, port-c, port-s
    function automatic logic [7:0] key_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] ch;
        logic [7:0] tail;
        tail = k[0] ? 8'h73 : 8'h63;
        if (!k[1]) begin
            unique case (p)
                3'd0:    ch = 8'h73;
                3'd1:    ch = 8'h70;
                3'd2:    ch = 8'h69;
                3'd3:    ch = 8'h2D;
                3'd4:    ch = tail;
                default: ch = 8'h00;
            endcase
        end else begin
            unique case (p)
                3'd0:    ch = 8'h70;
                3'd1:    ch = 8'h6F;
                3'd2:    ch = 8'h72;
                3'd3:    ch = 8'h74;
                3'd4:    ch = 8'h2D;
                3'd5:    ch = tail;
                default: ch = 8'h00;
            endcase
        end
        return ch;
    endfunction

    function automatic logic [2:0] key_len(input logic [1:0] k);
        return k[1] ? 3'd6 : 3'd5;
    endfunction

    function automatic t_digit digit_of(input logic [7:0] c, input logic hex);
        t_digit d;
        d.ok  = 1'b0;
        d.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h30);
        end else if (hex && c >= 8'h61 && c <= 8'h66) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h61 + 8'd10);
        end else if (hex && c >= 8'h41 && c <= 8'h46) begin
            d.ok  = 1'b1;
            d.val = 4'(c - 8'h41 + 8'd10);
        end
        return d;
    endfunction

endpackage

// ----- rtl/ishp_in_if.sv -----
// Character channel into the security header parser.
// No dependencies.
interface ishp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink   (input valid, input text_char, input last_char, output ready);
endinterface

// ----- rtl/ishp_out_if.sv -----
// Result channel out of the security header parser.
// Depends on ishp_pkg.
interface ishp_out_if;
    logic               valid;
    logic               ready;
    ishp_pkg::t_status  status;
    ishp_pkg::t_value   spi_client;
    ishp_pkg::t_value   spi_server;
    ishp_pkg::t_value   port_client;
    ishp_pkg::t_value   port_server;

    modport source (output valid, output status, output spi_client, output spi_server,
                    output port_client, output port_server, input ready);
    modport sink   (input valid, input status, input spi_client, input spi_server,
                    input port_client, input port_server, output ready);
endinterface

// ----- rtl/ipsec_security_header_parser_top.sv -----
// Security-agreement header parser: one character per word, one result per header.
// Depends on ishp_pkg, ishp_in_if, ishp_out_if and the assertion macro header.
//
// Takes one header character per cycle, sustained. A character sits in an input
// register, then one update advances the mechanism matcher, the four key matchers
// and the four value accumulators (shift-add by ten or sixteen) at once; that update
// sets the rate. The word carrying the final character loads the result into the
// output register when it leaves the input register, and all parse state clears
// so the next word starts a new header. Ready drops only while a final character
// waits in the input register behind an untaken result; other characters keep flowing.
module ipsec_security_header_parser_top #(
    parameter int TEXT_BUFFER_BYTES  = 512,
    parameter int VALUE_BUFFER_BYTES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ishp_in_if.sink       i_in,
    ishp_out_if.source    o_out
);
    import ishp_pkg::*;

    localparam int PW = $clog2(TEXT_BUFFER_BYTES);
    localparam int VW = $clog2(VALUE_BUFFER_BYTES);
    localparam logic [PW-1:0] POS_LIMIT = PW'(TEXT_BUFFER_BYTES - 1);
    localparam logic [VW-1:0] VAL_LIMIT = VW'(VALUE_BUFFER_BYTES - 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;

    // parse state
    logic [PW-1:0]        r_pos,       n_pos;
    logic                 r_ended,     n_ended;
    logic [3:0]           r_mech_prog, n_mech_prog;
    logic                 r_mech_seen, n_mech_seen;
    logic [2:0]           r_key_prog [KEY_COUNT];
    logic [2:0]           n_key_prog [KEY_COUNT];
    logic [KEY_COUNT-1:0] r_found,     n_found;
    logic [KEY_COUNT-1:0] r_capt,      n_capt;
    logic [KEY_COUNT-1:0] r_hex,       n_hex;
    logic [KEY_COUNT-1:0] r_stop,      n_stop;
    logic [VW-1:0]        r_vcnt     [KEY_COUNT];
    logic [VW-1:0]        n_vcnt     [KEY_COUNT];
    t_value               r_acc      [KEY_COUNT];
    t_value               n_acc      [KEY_COUNT];

    // output register
    logic    r_out_valid;
    t_result r_out;
    t_result w_result;

    logic w_out_free;
    logic w_proc;
    logic w_accept;

    assign w_out_free = !r_out_valid || o_out.ready;
    // a non-final word never waits on the result side
    assign w_proc     = r_in_valid && (!r_in_last || w_out_free);
    assign i_in.ready = !r_in_valid || w_proc;
    assign w_accept   = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_char <= i_in.text_char;
            r_in_last <= i_in.last_char;
        end
    end

    // per-character update
    always_comb begin
        logic [3:0] mp;
        t_digit     dv;
        logic [7:0] c;
        logic [2:0] kp;
        logic [7:0] first;
        c           = r_in_char;
        mp          = 4'd0;
        dv          = '0;
        kp          = 3'd0;
        first       = 8'd0;
        n_pos       = r_pos;
        n_ended     = r_ended;
        n_mech_prog = r_mech_prog;
        n_mech_seen = r_mech_seen;
        n_found     = r_found;
        n_capt      = r_capt;
        n_hex       = r_hex;
        n_stop      = r_stop;
        for (int k = 0; k < KEY_COUNT; k++) begin
            n_key_prog[k] = r_key_prog[k];
            n_vcnt[k]     = r_vcnt[k];
            n_acc[k]      = r_acc[k];
        end
        if (!r_ended && (r_pos < POS_LIMIT)) begin
            if (c == CH_NUL || c == CH_COMMA) begin
                n_ended = 1'b1;
            end else begin
                n_pos = r_pos + PW'(1);
                if (!r_mech_seen) begin
                    if (c == mech_char(r_mech_prog)) begin
                        mp = r_mech_prog + 4'd1;
                    end else begin
                        mp = (c == CH_I) ? 4'd1 : 4'd0;
                    end
                    if (mp == MECH_LEN) begin
                        n_mech_seen = 1'b1;
                        n_mech_prog = 4'd0;
                    end else begin
                        n_mech_prog = mp;
                    end
                end
                for (int k = 0; k < KEY_COUNT; k++) begin
                    // value capture
                    if (r_capt[k]) begin
                        if (c == CH_SEMI) begin
                            n_capt[k] = 1'b0;
                        end else if (r_vcnt[k] < VAL_LIMIT) begin
                            n_vcnt[k] = r_vcnt[k] + VW'(1);
                            if (!r_stop[k]) begin
                                if (r_vcnt[k] == VW'(1) && !r_hex[k] && r_acc[k] == '0 &&
                                    (c == CH_X_LO || c == CH_X_UP)) begin
                                    n_hex[k] = 1'b1;
                                end else begin
                                    dv = digit_of(c, r_hex[k]);
                                    if (!dv.ok) begin
                                        n_stop[k] = 1'b1;
                                    end else if (r_hex[k]) begin
                                        n_acc[k] = {r_acc[k][VALUE_W-5:0], 4'b0000}
                                                 + VALUE_W'(dv.val);
                                    end else begin
                                        n_acc[k] = (r_acc[k] << 3) + (r_acc[k] << 1)
                                                 + VALUE_W'(dv.val);
                                    end
                                end
                            end
                        end
                    end
                    // key matcher
                    kp    = r_key_prog[k];
                    first = key_char(2'(k), 3'd0);
                    if (!r_found[k]) begin
                        if (kp >= key_len(2'(k))) begin
                            if (c == CH_EQ) begin
                                n_found[k]    = 1'b1;
                                n_capt[k]     = 1'b1;
                                n_key_prog[k] = 3'd0;
                            end else begin
                                n_key_prog[k] = (c == first) ? 3'd1 : 3'd0;
                            end
                        end else if (c == key_char(2'(k), kp)) begin
                            n_key_prog[k] = kp + 3'd1;
                        end else begin
                            n_key_prog[k] = (c == first) ? 3'd1 : 3'd0;
                        end
                    end
                end
            end
        end
    end

    // report from the updated state
    always_comb begin
        logic ok;
        logic any_zero;
        ok              = n_mech_seen;
        any_zero        = 1'b0;
        w_result.value  = '0;
        for (int k = 0; k < KEY_COUNT; k++) begin
            ok = ok && n_found[k];
            if (ok) begin
                w_result.value[k] = n_acc[k];
            end
            if (n_acc[k] == '0) begin
                any_zero = 1'b1;
            end
        end
        if (!n_mech_seen) begin
            w_result.status = ST_NO_MECH;
        end else if (!(&n_found)) begin
            w_result.status = ST_NO_KEY;
        end else if (any_zero) begin
            w_result.status = ST_ZERO_VALUE;
        end else begin
            w_result.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proc && r_in_last)) begin
            r_pos       <= '0;
            r_ended     <= 1'b0;
            r_mech_prog <= 4'd0;
            r_mech_seen <= 1'b0;
            r_found     <= '0;
            r_capt      <= '0;
            r_hex       <= '0;
            r_stop      <= '0;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key_prog[k] <= 3'd0;
                r_vcnt[k]     <= '0;
                r_acc[k]      <= '0;
            end
        end else if (w_proc) begin
            r_pos       <= n_pos;
            r_ended     <= n_ended;
            r_mech_prog <= n_mech_prog;
            r_mech_seen <= n_mech_seen;
            r_found     <= n_found;
            r_capt      <= n_capt;
            r_hex       <= n_hex;
            r_stop      <= n_stop;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_key_prog[k] <= n_key_prog[k];
                r_vcnt[k]     <= n_vcnt[k];
                r_acc[k]      <= n_acc[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proc && r_in_last) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out.status;
    assign o_out.spi_client  = r_out.value[0];
    assign o_out.spi_server  = r_out.value[1];
    assign o_out.port_client = r_out.value[2];
    assign o_out.port_server = r_out.value[3];

`include "ipsec_security_header_parser_top_assert.svh"

    `ISHP_ASSERT_NEXT(a_clear_after_report, i_clk, i_rst_n, (w_proc && r_in_last), ((r_pos == '0) && !r_ended && !r_mech_seen && (r_found == '0)))
    `ISHP_ASSERT_IMPLIES(a_capture_needs_key, i_clk, i_rst_n, 1'b1, ((r_capt & ~r_found) == '0))
    `ISHP_ASSERT_IMPLIES(a_ok_values_nonzero, i_clk, i_rst_n, (r_out_valid && (r_out.status == ST_OK)), ((r_out.value[0] != '0) && (r_out.value[1] != '0) && (r_out.value[2] != '0) && (r_out.value[3] != '0)))
    `ISHP_ASSERT_IMPLIES(a_no_mech_zero_values, i_clk, i_rst_n, (r_out_valid && (r_out.status == ST_NO_MECH)), (r_out.value == '0))
    `ISHP_ASSERT_NEXT(a_hold_unprocessed_word, i_clk, i_rst_n, (r_in_valid && !w_proc), (r_in_valid && $stable(r_in_char) && $stable(r_in_last)))

endmodule
